### design/mandelbrot_escape_time_pixel_core_macros.svh
// assertion helpers used by the top-level design file
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mbe_pkg.sv
package mbe_pkg;

  // fixed point format of the coordinates
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int STEP_W    = 31;
  localparam int ITER_W    = 16;
  localparam int ARGB_W    = 32;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 10;

  // stream and config port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // derived datapath widths
  localparam int MAG_W   = FRAC_BITS + 2;          // |z| component once below 2.0
  localparam int PROD_W  = 2 * MAG_W;              // square or cross product
  localparam int SQ_W    = PROD_W - FRAC_BITS;     // rescaled square
  localparam int XY_W    = PROD_W - FRAC_BITS + 1; // rescaled doubled cross product
  localparam int Z_W     = COORD_W + 2;            // z component, exact
  localparam int CPROD_W = COL_W + STEP_W;
  localparam int RPROD_W = ROW_W + STEP_W;
  localparam int SUM_W   = CPROD_W + 2;

  // register reset values
  localparam logic signed [COORD_W-1:0] REAL_MIN_RST  = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] IMAG_MAX_RST  = 32'sd402653184;
  localparam logic        [STEP_W-1:0]  STEP_REAL_RST = 31'd629146;
  localparam logic        [STEP_W-1:0]  STEP_IMAG_RST = 31'd1118481;
  localparam logic        [ITER_W-1:0]  MAX_ITER_RST  = 16'd25600;

  // colour constants
  localparam logic [ARGB_W-1:0] ARGB_BLACK = 32'hFF00_0000;
  localparam logic [7:0]        SHADE_MAX  = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REAL_MIN  = 3'd0,
    CFG_IMAG_MAX  = 3'd1,
    CFG_STEP_REAL = 3'd2,
    CFG_STEP_IMAG = 3'd3,
    CFG_MAX_ITER  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CHECK,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;  // capture pixel, form column and row offsets
    logic init;  // form c and start z at c
    logic mul;   // escape bound check and products
    logic step;  // take the new z and count
    logic emit;  // hand the result to the output buffer
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_limit;
    logic escaped;
  } dp_sts_t;

endpackage

### design/mbe_ctrl.sv
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_sts_t    sts,
  input  logic       out_free,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_INIT;
      end
      ST_INIT:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.at_limit ? ST_FIN : ST_UPD;
      ST_UPD:   state_nxt = sts.escaped ? ST_FIN : ST_CHECK;
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_INIT:  cmd.init = 1'b1;
      ST_CHECK: cmd.mul  = !sts.at_limit;
      ST_UPD:   cmd.step = !sts.escaped;
      ST_FIN:   cmd.emit = out_free;
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### design/mbe_dp.sv
module mbe_dp
  import mbe_pkg::*;
#(
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [COL_W-1:0]      in_col,
  input  logic [ROW_W-1:0]      in_row,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  output logic [ITER_W-1:0]     res_count,
  output logic [ARGB_W-1:0]     res_argb
);

  localparam logic [Z_W-1:0]  LIMIT2 = Z_W'(2) << FRAC_BITS;
  localparam logic [SQ_W:0]   LIMIT4 = (SQ_W + 1)'(4) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] C_MAX =
    {{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] C_MIN =
    {{(SUM_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > C_MAX) begin
      r = C_MAX[COORD_W-1:0];
    end else if (v < C_MIN) begin
      r = C_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [COORD_W-1:0] real_min_r, imag_max_r;
  logic [STEP_W-1:0]         step_real_r, step_imag_r;
  logic [ITER_W-1:0]         max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_min_r  <= REAL_MIN_RST;
      imag_max_r  <= IMAG_MAX_RST;
      step_real_r <= STEP_REAL_RST;
      step_imag_r <= STEP_IMAG_RST;
      max_iter_r  <= MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_REAL_MIN:  real_min_r  <= cfg_wdata[COORD_W-1:0];
        CFG_IMAG_MAX:  imag_max_r  <= cfg_wdata[COORD_W-1:0];
        CFG_STEP_REAL: step_real_r <= cfg_wdata[STEP_W-1:0];
        CFG_STEP_IMAG: step_imag_r <= cfg_wdata[STEP_W-1:0];
        CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel offsets from the image edges
  logic [COL_W-1:0]   col_sat;
  logic [ROW_W-1:0]   row_sat;
  logic [CPROD_W-1:0] colprod_r, colprod_nxt;
  logic [RPROD_W-1:0] rowprod_r, rowprod_nxt;

  always_comb begin
    col_sat = (32'(in_col) > 32'(MAX_COLUMNS - 1)) ? COL_W'(MAX_COLUMNS - 1) : in_col;
    row_sat = (32'(in_row) > 32'(MAX_ROWS - 1)) ? ROW_W'(MAX_ROWS - 1) : in_row;
    colprod_nxt = CPROD_W'(col_sat) * CPROD_W'(step_real_r);
    rowprod_nxt = RPROD_W'(row_sat) * RPROD_W'(step_imag_r);
  end

  // point c, saturated to the coordinate range
  logic signed [SUM_W-1:0]   cx_sum, cy_sum;
  logic signed [COORD_W-1:0] cx_r, cy_r;

  always_comb begin
    cx_sum = $signed({{(SUM_W - COORD_W){real_min_r[COORD_W-1]}}, real_min_r})
           + $signed({{(SUM_W - CPROD_W){1'b0}}, colprod_r});
    cy_sum = $signed({{(SUM_W - COORD_W){imag_max_r[COORD_W-1]}}, imag_max_r})
           - $signed({{(SUM_W - RPROD_W){1'b0}}, rowprod_r});
  end

  // first half of an iteration: bound check and products
  logic signed [Z_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [Z_W-1:0]        ax, ay;
  logic [PROD_W-1:0]     pxx_r, pyy_r, pxy_r;
  logic                  big_r, sdiff_r;
  logic [ITER_W-1:0]     count_r;

  always_comb begin
    ax = x_r[Z_W-1] ? Z_W'(-x_r) : Z_W'(x_r);
    ay = y_r[Z_W-1] ? Z_W'(-y_r) : Z_W'(y_r);
  end

  // second half: escape test and next z
  logic [SQ_W-1:0]       xx, yy;
  logic [SQ_W:0]         mag2;
  logic [XY_W-1:0]       m_adj;
  logic                  rest;
  logic [Z_W-1:0]        xy2_mag;
  logic signed [Z_W-1:0] xy2;

  always_comb begin
    xx      = pxx_r[PROD_W-1:FRAC_BITS];
    yy      = pyy_r[PROD_W-1:FRAC_BITS];
    mag2    = {1'b0, xx} + {1'b0, yy};
    rest    = |pxy_r[FRAC_BITS-2:0];
    // negative cross product rounds toward minus infinity
    m_adj   = pxy_r[PROD_W-1:FRAC_BITS-1] + XY_W'(rest && sdiff_r);
    xy2_mag = {{(Z_W - XY_W){1'b0}}, m_adj};
    xy2     = sdiff_r ? -$signed(xy2_mag) : $signed(xy2_mag);
    x_nxt   = $signed({{(Z_W - SQ_W){1'b0}}, xx}) - $signed({{(Z_W - SQ_W){1'b0}}, yy})
            + $signed({{(Z_W - COORD_W){cx_r[COORD_W-1]}}, cx_r});
    y_nxt   = xy2 + $signed({{(Z_W - COORD_W){cy_r[COORD_W-1]}}, cy_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      colprod_r <= colprod_nxt;
      rowprod_r <= rowprod_nxt;
    end
    if (cmd.init) begin
      cx_r    <= sat_coord(cx_sum);
      cy_r    <= sat_coord(cy_sum);
      // sign-extend the start value of z
      x_r     <= Z_W'(sat_coord(cx_sum));
      y_r     <= Z_W'(sat_coord(cy_sum));
      count_r <= '0;
    end
    if (cmd.mul) begin
      big_r   <= (ax > LIMIT2) || (ay > LIMIT2);
      sdiff_r <= x_r[Z_W-1] ^ y_r[Z_W-1];
      pxx_r   <= PROD_W'(ax[MAG_W-1:0]) * PROD_W'(ax[MAG_W-1:0]);
      pyy_r   <= PROD_W'(ay[MAG_W-1:0]) * PROD_W'(ay[MAG_W-1:0]);
      pxy_r   <= PROD_W'(ax[MAG_W-1:0]) * PROD_W'(ay[MAG_W-1:0]);
    end
    if (cmd.step) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      count_r <= count_r + ITER_W'(1);
    end
  end

  logic [7:0] shade;

  always_comb begin
    sts.at_limit = (count_r == max_iter_r);
    sts.escaped  = big_r || (mag2 > LIMIT4);
    shade        = (count_r > ITER_W'(SHADE_MAX)) ? SHADE_MAX : count_r[7:0];
    res_count    = count_r;
    res_argb     = sts.at_limit ? ARGB_BLACK
                                : (ARGB_BLACK | {8'h00, shade, 8'h00, shade});
  end

endmodule

### design/mbe_obuf.sv
module mbe_obuf
  import mbe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic [OUT_TDATA_W-1:0] data,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;

  always_comb begin
    free      = !valid_r || out_tready;
    valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= data;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

### design/mandelbrot_escape_time_pixel_core.sv
// Mandelbrot escape-time pixel core: each input transfer carries one pixel's column and row;
// the core forms c = (real_min + column*step_real, imag_max - row*step_imag) in signed Q4.28,
// saturated to 32 bits, iterates z = z*z + c from z = c while |z|^2 <= 4 and the count is below
// max_iter, and returns one output transfer with the count and an ARGB colour (opaque black for
// points that reached the limit, else red = blue = min(count,255)). One pixel is worked at a
// time: from its input transfer the core sets up c and z = c, then iterates, each iteration
// being a bound check with the squares and cross product, followed by the rescale, escape
// test and z update, until the result is loaded into the output register. The next pixel can
// be taken in the cycle after that load, even while the result waits for out_tready.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the core is idle, as the core itself does not enforce this.
`include "mandelbrot_escape_time_pixel_core_macros.svh"

module mandelbrot_escape_time_pixel_core
  import mbe_pkg::*;
#(
  parameter int MAX_COLUMNS = 2048,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // pixel input
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // column[10:0], row[20:11], zero pad
  // result output
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // iteration_count[15:0], pixel_argb[47:16]
);

  ctrl_cmd_t         ctrl_cmd;
  dp_sts_t           dp_sts;
  logic              out_free;
  logic [ITER_W-1:0] res_count;
  logic [ARGB_W-1:0] res_argb;

  // sequencer: idle, setup, then bound/product and update cycles per iteration, then a finish state
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .out_free  (out_free),
    .cmd       (ctrl_cmd)
  );

  // config registers, coordinate setup and the iteration arithmetic
  mbe_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_col    (in_tdata[COL_W-1:0]),
    .in_row    (in_tdata[COL_W+ROW_W-1:COL_W]),
    .cmd       (ctrl_cmd),
    .sts       (dp_sts),
    .res_count (res_count),
    .res_argb  (res_argb)
  );

  // output register, frees the core while a result waits
  mbe_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctrl_cmd.emit),
    .data       ({res_argb, res_count}),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // results only go to a free output register, and show up there next cycle
  `MBE_ASSERT_IMP(a_emit_free, ctrl_cmd.emit, out_free, "result emitted into a full buffer")
  `MBE_ASSERT_NXT(a_emit_shows, ctrl_cmd.emit, out_tvalid, "emitted result not presented")
  // one pixel at a time: busy right after an input transfer
  `MBE_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready,
                  "second pixel taken while busy")
  // z is never advanced once the count has reached the limit
  `MBE_ASSERT_IMP(a_step_below_limit, ctrl_cmd.step, !dp_sts.at_limit,
                  "iteration past the limit")

endmodule
